// ===== rtl/core/ghst_pkg.sv =====
// Shared types and constants for the generational handle slot table.
`default_nettype none
package ghst_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int SLOT_IDX_W     = 3;
  localparam int GEN_W          = 12;
  localparam int HANDLE_W       = 16;
  localparam int SYS_W          = 15;
  localparam int REFS_W         = 16;
  localparam int ROLE_W         = 2;
  localparam int ROLE_COUNT     = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int REQ_W          = 3;
  localparam int LOAD_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int KIND_W         = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC       = 3'd0,
    REQ_GUEST_REL   = 3'd1,
    REQ_SCENE_RET   = 3'd2,
    REQ_SCENE_REL   = 3'd3,
    REQ_RELEASE_ALL = 3'd4,
    REQ_RESOLVE     = 3'd5
  } req_t;

  typedef enum logic [LOAD_W-1:0] {
    LOAD_OK    = 2'd0,
    LOAD_NOMEM = 2'd1,
    LOAD_BAD   = 2'd2
  } load_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_SYS  = 2'd1,
    KIND_DYN  = 2'd2
  } kind_t;

  typedef enum logic [ROLE_W-1:0] {
    ROLE_SMALL  = 2'd0,
    ROLE_MEDIUM = 2'd1,
    ROLE_LARGE  = 2'd2,
    ROLE_TITLE  = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_EXEC = 3'b010,
    CS_RESP = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic respond;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/ghst_ctrl.sv =====
// Request sequencer: capture, execute, respond.
`default_nettype none
module ghst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output ghst_pkg::ctrl_cmd_t cmd
);
  import ghst_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (start) state_next = CS_EXEC;
      end
      CS_EXEC: state_next = CS_RESP;
      CS_RESP: state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  assign busy        = (state != CS_IDLE);
  assign cmd.capture = (state == CS_IDLE) && start;
  assign cmd.execute = (state == CS_EXEC);
  assign cmd.respond = (state == CS_RESP);
  assign done        = cmd.respond;

  a_cap_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute) else $error("capture not followed by execute");
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (cmd.respond && busy)) else $error("execute not followed by respond");
  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |=> !busy) else $error("busy after respond");

endmodule
`default_nettype wire

// ===== rtl/core/ghst_datapath.sv =====
// Slot registers, system handle registers, request evaluation and result registers.
`default_nettype none
module ghst_datapath #(
  parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ghst_pkg::ctrl_cmd_t            cmd,
  input  logic [ghst_pkg::REQ_W-1:0]     req_type,
  input  logic [ghst_pkg::HANDLE_W-1:0]  handle,
  input  logic [ghst_pkg::LOAD_W-1:0]    load_result,
  input  logic                           cfg_we,
  input  logic [ghst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghst_pkg::SYS_W-1:0]     cfg_data,
  output logic [ghst_pkg::STATUS_W-1:0]  status,
  output logic                           accepted,
  output logic [ghst_pkg::HANDLE_W-1:0]  new_handle,
  output logic [ghst_pkg::KIND_W-1:0]    resolve_kind,
  output logic [ghst_pkg::SLOT_IDX_W-1:0] resolved_slot,
  output logic [ghst_pkg::ROLE_W-1:0]    resolved_role
);
  import ghst_pkg::*;

  // captured request
  req_t                  req_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [LOAD_W-1:0]     load_q;

  // slot state
  logic [GEN_W-1:0]      gen  [SLOT_COUNT];
  logic [REFS_W-1:0]     refs [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ;
  logic [SLOT_COUNT-1:0] own;

  logic [SYS_W-1:0]      sys [ROLE_COUNT];

  // decoded handle
  logic                  dyn;
  logic [GEN_W-1:0]      hgen;
  logic [SLOT_IDX_W-1:0] hidx;

  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] first_free;
  logic [SLOT_COUNT-1:0] refs_nz;
  logic [SLOT_COUNT-1:0] refs_max;
  logic [GEN_W-1:0]      gen_inc [SLOT_COUNT];
  logic                  any_free;
  logic [GEN_W-1:0]      alloc_gen;
  logic [SLOT_IDX_W-1:0] alloc_slot;
  logic                  alloc_ok;
  logic                  hit_own;
  logic                  hit_room;

  logic [ROLE_COUNT-1:0] sys_hit;
  role_t                 sys_role;

  status_t               status_next;
  logic                  accepted_next;
  logic [HANDLE_W-1:0]   new_handle_next;
  kind_t                 kind_next;
  logic [SLOT_IDX_W-1:0] rslot_next;
  role_t                 role_next;

  status_t               status_q;
  kind_t                 kind_q;
  role_t                 role_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_t'(req_type);
      handle_q <= handle;
      load_q   <= load_result;
    end
  end

  assign dyn  = handle_q[HANDLE_W-1];
  assign hgen = handle_q[HANDLE_W-2:SLOT_IDX_W];
  assign hidx = handle_q[SLOT_IDX_W-1:0];

  always_comb begin
    logic found;
    found      = 1'b0;
    alloc_gen  = '0;
    alloc_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]        = dyn && (hgen != '0) && (hidx == SLOT_IDX_W'(i)) && occ[i]
                      && (gen[i] == hgen);
      refs_nz[i]    = (refs[i] != '0);
      refs_max[i]   = (refs[i] == {REFS_W{1'b1}});
      gen_inc[i]    = (gen[i] + GEN_W'(1) == '0) ? GEN_W'(1) : gen[i] + GEN_W'(1);
      first_free[i] = !occ[i] && !found;
      if (!occ[i]) found = 1'b1;
      if (first_free[i]) begin
        alloc_gen  = gen_inc[i];
        alloc_slot = SLOT_IDX_W'(i);
      end
    end
    any_free = found;
  end

  assign alloc_ok = any_free && (load_q == LOAD_OK);
  assign hit_own  = |(hit & own);
  assign hit_room = |(hit & own & ~refs_max);

  always_comb begin
    for (int r = 0; r < ROLE_COUNT; r++) begin
      sys_hit[r] = !dyn && (handle_q[SYS_W-1:0] == sys[r]);
    end
  end

  // title wins over large, medium, small
  always_comb begin
    priority if (sys_hit[ROLE_TITLE])  sys_role = ROLE_TITLE;
    else if (sys_hit[ROLE_LARGE])      sys_role = ROLE_LARGE;
    else if (sys_hit[ROLE_MEDIUM])     sys_role = ROLE_MEDIUM;
    else                               sys_role = ROLE_SMALL;
  end

  always_comb begin
    status_next     = ST_OK;
    accepted_next   = 1'b0;
    new_handle_next = '0;
    kind_next       = KIND_NONE;
    rslot_next      = '0;
    role_next       = ROLE_SMALL;
    unique case (req_q)
      REQ_ALLOC: begin
        if (!any_free) status_next = ST_EXHAUSTED;
        else if (load_q == LOAD_NOMEM) status_next = ST_EXHAUSTED;
        else if (load_q != LOAD_OK) status_next = ST_INVALID;
        else new_handle_next = {1'b1, alloc_gen, alloc_slot};
      end
      REQ_GUEST_REL: begin
        if (!hit_own) status_next = ST_INVALID;
      end
      REQ_SCENE_RET: begin
        accepted_next = dyn ? hit_room : |sys_hit;
      end
      REQ_SCENE_REL: ;
      REQ_RELEASE_ALL: ;
      REQ_RESOLVE: begin
        if (!dyn) begin
          if (|sys_hit) begin
            kind_next = KIND_SYS;
            role_next = sys_role;
          end
        end else if (hit_own) begin
          kind_next  = KIND_DYN;
          rslot_next = hidx;
        end
      end
      default: status_next = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_q      <= status_next;
      accepted      <= accepted_next;
      new_handle    <= new_handle_next;
      kind_q        <= kind_next;
      resolved_slot <= rslot_next;
      role_q        <= role_next;
    end
  end

  assign status        = status_q;
  assign resolve_kind  = kind_q;
  assign resolved_role = role_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        gen[i]  <= '0;
        refs[i] <= '0;
      end
      occ <= '0;
      own <= '0;
    end else if (cmd.execute) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        unique case (req_q)
          REQ_ALLOC: begin
            if (alloc_ok && first_free[i]) begin
              gen[i]  <= gen_inc[i];
              occ[i]  <= 1'b1;
              own[i]  <= 1'b1;
              refs[i] <= '0;
            end
          end
          REQ_GUEST_REL: begin
            if (hit[i] && own[i]) begin
              own[i] <= 1'b0;
              if (!refs_nz[i]) occ[i] <= 1'b0;
            end
          end
          REQ_SCENE_RET: begin
            if (hit[i] && own[i] && !refs_max[i]) refs[i] <= refs[i] + REFS_W'(1);
          end
          REQ_SCENE_REL: begin
            if (hit[i] && refs_nz[i]) begin
              refs[i] <= refs[i] - REFS_W'(1);
              if (refs[i] == REFS_W'(1) && !own[i]) occ[i] <= 1'b0;
            end
          end
          REQ_RELEASE_ALL: begin
            own[i] <= 1'b0;
            if (!refs_nz[i]) occ[i] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROLE_COUNT; r++) begin
        sys[r] <= SYS_W'(r);
      end
    end else if (cfg_we) begin
      sys[cfg_index] <= cfg_data;
    end
  end

  a_own_occ: assert property (@(posedge clk) disable iff (rst)
    (own & ~occ) == '0) else $error("guest-owned slot not occupied");
  a_refs_occ: assert property (@(posedge clk) disable iff (rst)
    (refs_nz & ~occ) == '0) else $error("referenced slot not occupied");
  a_new_dyn: assert property (@(posedge clk) disable iff (rst)
    cmd.respond && (new_handle != '0) |-> new_handle[HANDLE_W-1] && (status_q == ST_OK))
    else $error("issued handle malformed");

endmodule
`default_nettype wire

// ===== rtl/core/generational_handle_slot_table_top.sv =====
// Top level of the generational handle slot table.
// A request is taken on start while busy is low and passes in turn through the
// capture edge, the execute state, in which all slot registers are evaluated in
// parallel and updated, and the respond state, in which done pulses with the
// result on the result ports; the next start is taken the cycle after done, so
// no new request is taken before the last one is done. done is high for exactly
// one cycle and cannot be held off; the result ports keep their word until the
// next result. cfg_ready is always high; write the system handle registers only
// while busy is low. Reset needs no sweep.
`default_nettype none
module generational_handle_slot_table_top #(
  parameter int SLOT_COUNT = ghst_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ghst_pkg::REQ_W-1:0]      req_type,
  input  logic [ghst_pkg::HANDLE_W-1:0]   handle,
  input  logic [ghst_pkg::LOAD_W-1:0]     load_result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ghst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ghst_pkg::SYS_W-1:0]      cfg_data,
  output logic                            done,
  output logic [ghst_pkg::STATUS_W-1:0]   status,
  output logic                            accepted,
  output logic [ghst_pkg::HANDLE_W-1:0]   new_handle,
  output logic [ghst_pkg::KIND_W-1:0]     resolve_kind,
  output logic [ghst_pkg::SLOT_IDX_W-1:0] resolved_slot,
  output logic [ghst_pkg::ROLE_W-1:0]     resolved_role
);
  import ghst_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ghst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ghst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_type      (req_type),
    .handle        (handle),
    .load_result   (load_result),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .accepted      (accepted),
    .new_handle    (new_handle),
    .resolve_kind  (resolve_kind),
    .resolved_slot (resolved_slot),
    .resolved_role (resolved_role)
  );

endmodule
`default_nettype wire
